>>> hw/rtl/ctbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbf_pkg
// Types, constants and small helper functions shared by the chord template
// best-fit matcher.
// ----------------------------------------------------------------------------
package ctbf_pkg;

  localparam int CLASS_COUNT = 12;

  typedef logic [CLASS_COUNT-1:0] class_mask_t;

  // Command codes carried in the input word.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Input word: one load or one query.
  typedef struct packed {
    logic        command;
    logic [5:0]  entry_index;
    class_mask_t entry_mask;
    logic [4:0]  entry_tones;
    logic        entry_is_scale;
    class_mask_t sounding_mask;
    logic [3:0]  query_root;
  } in_word_t;

  // Result word: one per query.
  typedef struct packed {
    logic        fit_found;
    logic [5:0]  fit_entry;
    logic [3:0]  fit_root;
    class_mask_t fit_missing_mask;
    class_mask_t fit_extra_mask;
    logic        fit_exact;
    logic        exact_found;
    logic [5:0]  exact_entry;
    logic        scale_found;
    logic [5:0]  scale_entry;
  } out_word_t;

  // One stored template.
  typedef struct packed {
    class_mask_t mask;
    logic [4:0]  tones;
    logic        scale_flag;
  } tmpl_t;

  // Status handed from the match unit to the top level.
  typedef struct packed {
    logic        fit_found;
    logic [3:0]  fit_root;
    class_mask_t fit_missing;
    class_mask_t fit_extra;
    logic        fit_exact;
    logic        exact_found;
    logic        scale_found;
  } match_status_t;

  // Rotate a class mask left by root places within twelve bits.
  function automatic class_mask_t rotate_classes(input class_mask_t m,
                                                 input logic [3:0] r);
    logic [2*CLASS_COUNT-1:0] dbl;
    dbl = {m, m} << r;
    return dbl[2*CLASS_COUNT-1:CLASS_COUNT];
  endfunction

  // Count the set bits of a class mask.
  function automatic logic [3:0] count_classes(input class_mask_t m);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < CLASS_COUNT; i++) n = n + 4'(m[i]);
    return n;
  endfunction

endpackage

>>> hw/rtl/ctbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbf_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module ctbf_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ctbf_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbf_match
// Scores one template per cycle against the sounding set at all twelve roots,
// picks the best root, and merges it into the running best fit, exact match
// and covering scale.
// ----------------------------------------------------------------------------
module ctbf_match import ctbf_pkg::*; #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  class_mask_t   sounding_in,
  input  logic [3:0]    root_in,
  input  logic          rd_valid,
  input  logic [AW-1:0] rd_entry,
  input  tmpl_t         rd_data,
  output logic          busy,
  output match_status_t status,
  output logic [AW-1:0] fit_entry,
  output logic [AW-1:0] exact_entry,
  output logic [AW-1:0] scale_entry
);

  // Query context.
  class_mask_t snd;
  logic [3:0]  qroot;
  logic        multi;
  logic [3:0]  rank [CLASS_COUNT];
  logic [3:0]  rank_next [CLASS_COUNT];

  // Search order of each root: bass first, sounding next, others last.
  always_comb begin
    class_mask_t t, u, low;
    logic [3:0]  nt;
    t  = sounding_in & ~(class_mask_t'(1) << root_in);
    u  = ~sounding_in & ~(class_mask_t'(1) << root_in);
    nt = count_classes(t);
    for (int r = 0; r < CLASS_COUNT; r++) begin
      low = (class_mask_t'(1) << r) - class_mask_t'(1);
      if (4'(r) == root_in) begin
        rank_next[r] = 4'd0;
      end else if (sounding_in[r]) begin
        rank_next[r] = 4'd1 + count_classes(t & low);
      end else begin
        rank_next[r] = 4'd1 + nt + count_classes(u & low);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      snd   <= sounding_in;
      qroot <= root_in;
      multi <= count_classes(sounding_in) >= 4'd2;
      for (int r = 0; r < CLASS_COUNT; r++) rank[r] <= rank_next[r];
    end
  end

  // Stage one: per-root scores {missing, extra, rank, root}.
  logic [15:0] key_c [CLASS_COUNT];
  class_mask_t cmq;
  always_comb begin
    class_mask_t cm;
    for (int r = 0; r < CLASS_COUNT; r++) begin
      cm = rotate_classes(rd_data.mask, 4'(r));
      key_c[r] = {count_classes(cm & ~snd), count_classes(snd & ~cm), rank[r], 4'(r)};
    end
    cmq = rotate_classes(rd_data.mask, qroot);
  end

  logic          v2;
  logic [AW-1:0] e2;
  logic [15:0]   key2 [CLASS_COUNT];
  logic          elig2, exact2, scale2;
  logic [4:0]    tones2;
  class_mask_t   mask2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= rd_valid;
    end
    e2     <= rd_entry;
    key2   <= key_c;
    elig2  <= !rd_data.scale_flag && rd_data.tones >= 5'd2;
    exact2 <= !rd_data.scale_flag && rd_data.tones >= 5'd2 && multi && cmq == snd;
    scale2 <= rd_data.scale_flag && (snd & ~cmq) == '0;
    tones2 <= rd_data.tones;
    mask2  <= rd_data.mask;
  end

  // Stage two: minimum over the twelve roots, then merge.
  logic [15:0] l1 [6];
  logic [15:0] l2 [3];
  logic [15:0] l3, kmin;
  always_comb begin
    for (int i = 0; i < 6; i++) l1[i] = key2[2*i] < key2[2*i+1] ? key2[2*i] : key2[2*i+1];
    for (int i = 0; i < 3; i++) l2[i] = l1[2*i] < l1[2*i+1] ? l1[2*i] : l1[2*i+1];
    l3   = l2[0] < l2[1] ? l2[0] : l2[1];
    kmin = l3 < l2[2] ? l3 : l2[2];
  end

  logic        fit_found, exact_found, scale_found;
  logic [11:0] best_key;
  logic [3:0]  best_root;
  class_mask_t best_mask;
  logic [4:0]  best_tones;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_found   <= 1'b0;
      exact_found <= 1'b0;
      scale_found <= 1'b0;
    end else if (start) begin
      fit_found   <= 1'b0;
      exact_found <= 1'b0;
      scale_found <= 1'b0;
      fit_entry   <= '0;
      exact_entry <= '0;
      scale_entry <= '0;
      best_root   <= '0;
      best_mask   <= '0;
    end else if (v2) begin
      if (elig2 && (!fit_found || kmin[15:4] < best_key)) begin
        fit_found <= 1'b1;
        best_key  <= kmin[15:4];
        best_root <= kmin[3:0];
        best_mask <= mask2;
        fit_entry <= e2;
      end
      if (exact2 && !exact_found) begin
        exact_found <= 1'b1;
        exact_entry <= e2;
      end
      if (scale2 && (!scale_found || tones2 < best_tones)) begin
        scale_found <= 1'b1;
        best_tones  <= tones2;
        scale_entry <= e2;
      end
    end
  end

  // Result masks of the best fit.
  class_mask_t fit_cm;
  assign fit_cm = rotate_classes(best_mask, best_root);
  assign busy   = v2;

  always_comb begin
    status.fit_found   = fit_found;
    status.fit_root    = best_root;
    status.fit_missing = fit_found ? (fit_cm & ~snd) : '0;
    status.fit_extra   = fit_found ? (snd & ~fit_cm) : '0;
    status.fit_exact   = fit_found && fit_cm == snd;
    status.exact_found = exact_found;
    status.scale_found = scale_found;
  end

endmodule

>>> hw/rtl/chord_template_best_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chord_template_best_fit
// Chord and scale template matcher: loads templates, answers queries.
// ----------------------------------------------------------------------------
// A load word is written to the template RAM in the cycle it is accepted. A
// query reads the searched slots from the template RAM one per cycle through
// the single RAM read port and scores every slot at all twelve roots in
// parallel; the searched slots are the first table_entries slots, capped at
// MAX_ENTRIES, or none for an empty sounding mask. The result waits in an
// output register, and the next word is taken once the query has finished.
module chord_template_best_fit import ctbf_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int AW = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Configuration register.
  logic [6:0] table_entries;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      table_entries <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      table_entries <= cfg_data;
    end
  end

  logic accept, is_query, is_load;
  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign is_query = accept && in_word.command == CMD_QUERY;
  assign is_load  = accept && in_word.command == CMD_LOAD
                    && int'(in_word.entry_index) < MAX_ENTRIES;

  // Scan limit, taken at query start.
  logic [CW-1:0] limit, cnt;
  logic [3:0]    root_fold;
  assign root_fold = in_word.query_root >= 4'(CLASS_COUNT)
                     ? in_word.query_root - 4'(CLASS_COUNT) : in_word.query_root;

  logic issue;
  assign issue = state == S_SCAN && cnt < limit;

  // Template RAM.
  tmpl_t wdata, rdata;
  assign wdata = '{mask: in_word.entry_mask, tones: in_word.entry_tones,
                   scale_flag: in_word.entry_is_scale};

  ctbf_ram #(.WIDTH($bits(tmpl_t)), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (is_load),
    .waddr (AW'(in_word.entry_index)),
    .wdata (wdata),
    .re    (issue),
    .raddr (cnt[AW-1:0]),
    .rdata (rdata)
  );

  // Read-data valid flag and slot number, aligned with the RAM output.
  logic          v1;
  logic [AW-1:0] e1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= issue;
    end
    e1 <= cnt[AW-1:0];
  end

  logic          busy;
  match_status_t status;
  logic [AW-1:0] fit_entry, exact_entry, scale_entry;

  ctbf_match #(.AW(AW)) u_match (
    .clk         (clk),
    .rst         (rst),
    .start       (is_query),
    .sounding_in (in_word.sounding_mask),
    .root_in     (root_fold),
    .rd_valid    (v1),
    .rd_entry    (e1),
    .rd_data     (rdata),
    .busy        (busy),
    .status      (status),
    .fit_entry   (fit_entry),
    .exact_entry (exact_entry),
    .scale_entry (scale_entry)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (is_query) state_next = S_SCAN;
      S_SCAN:  if (cnt >= limit) state_next = S_DRAIN;
      S_DRAIN: if (!v1 && !busy) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      limit <= '0;
    end else begin
      state <= state_next;
      if (is_query) begin
        cnt <= '0;
        if (in_word.sounding_mask == '0) begin
          limit <= '0;
        end else if (int'(table_entries) > MAX_ENTRIES) begin
          limit <= CW'(MAX_ENTRIES);
        end else begin
          limit <= CW'(table_entries);
        end
      end else if (issue) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_word.fit_found        <= status.fit_found;
      out_word.fit_entry        <= 6'(fit_entry);
      out_word.fit_root         <= status.fit_root;
      out_word.fit_missing_mask <= status.fit_missing;
      out_word.fit_extra_mask   <= status.fit_extra;
      out_word.fit_exact        <= status.fit_exact;
      out_word.exact_found      <= status.exact_found;
      out_word.exact_entry      <= 6'(exact_entry);
      out_word.scale_found      <= status.scale_found;
      out_word.scale_entry      <= 6'(scale_entry);
    end
  end

  // The scan never runs past its limit.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cnt <= limit)
    else $error("scan counter passed its limit");

  // No RAM data is in flight while idle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !v1 && !busy)
    else $error("read data in flight while idle");

  // An exact fit is always a found fit.
  a_exact_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_word.fit_exact || out_word.fit_found)
    else $error("exact fit without a fit");

  // A result is loaded only when the register is free.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && out_stall |=> state == S_DONE)
    else $error("result left while output was stalled");

endmodule

>>> tb/tb_chord_template_best_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chord_template_best_fit
// Self-checking bench for the chord template matcher. Template loads and
// queries are driven with random gaps and output stalls. A behavioral model
// of the template table predicts every query answer, and each result word is
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_chord_template_best_fit import ctbf_pkg::*; ();

  localparam int SLOTS = 64;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  // Shadow copy of the template table and the searched-entry count.
  tmpl_t shadow_table [SLOTS];
  bit shadow_written [SLOTS];
  logic [6:0] search_count = '0;

  out_word_t pending_answers[$];
  int error_count = 0;
  int answers_seen = 0;
  int queries_sent = 0;
  int loads_sent = 0;
  longint cycle_count = 0;
  bit idle_enable = 1'b1;

  chord_template_best_fit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("chord_template_best_fit verification failed");
      $finish;
    end
  end

  function automatic int popcount12(input class_mask_t m);
    int n;
    n = 0;
    for (int i = 0; i < CLASS_COUNT; i++) n += m[i];
    return n;
  endfunction

  function automatic class_mask_t transpose(input class_mask_t m, input int r);
    class_mask_t t;
    for (int i = 0; i < CLASS_COUNT; i++) t[(i + r) % CLASS_COUNT] = m[i];
    return t;
  endfunction

  // Compute the three query answers from the shadow table.
  function automatic out_word_t match_answer(input class_mask_t snd, input logic [3:0] qr);
    out_word_t a;
    int bass, lim, nsnd, nroots, nm, nx, best_m, best_x, best_t;
    int roots [12];
    class_mask_t cm, miss, extra;
    tmpl_t t;
    a = '0;
    bass = (qr >= 12) ? qr - 12 : qr;
    lim = (search_count > SLOTS) ? SLOTS : search_count;
    nsnd = popcount12(snd);
    nroots = 0;
    best_m = 0; best_x = 0; best_t = 0;
    roots[nroots++] = bass;
    for (int k = 0; k < 2; k++)
      for (int i = 0; i < CLASS_COUNT; i++)
        if (i != bass && ((k == 0) == snd[i])) roots[nroots++] = i;
    if (nsnd > 0) begin
      for (int ri = 0; ri < 12; ri++) begin
        for (int e = 0; e < lim; e++) begin
          t = shadow_table[e];
          if (t.scale_flag || t.tones < 2) continue;
          cm = transpose(t.mask, roots[ri]);
          miss = cm & ~snd;
          extra = snd & ~cm;
          nm = popcount12(miss);
          nx = popcount12(extra);
          if (!a.fit_found || nm < best_m || (nm == best_m && nx < best_x)) begin
            a.fit_found = 1'b1;
            a.fit_entry = 6'(e);
            a.fit_root = 4'(roots[ri]);
            a.fit_missing_mask = miss;
            a.fit_extra_mask = extra;
            best_m = nm;
            best_x = nx;
          end
        end
      end
      for (int e = 0; e < lim; e++) begin
        t = shadow_table[e];
        cm = transpose(t.mask, bass);
        if (t.scale_flag) begin
          if ((snd & ~cm) != 0) continue;
          if (!a.scale_found || t.tones < best_t) begin
            a.scale_found = 1'b1;
            a.scale_entry = 6'(e);
            best_t = t.tones;
          end
        end else if (!a.exact_found && nsnd >= 2 && t.tones >= 2 && cm == snd) begin
          a.exact_found = 1'b1;
          a.exact_entry = 6'(e);
        end
      end
    end
    a.fit_exact = a.fit_found && a.fit_missing_mask == 0 && a.fit_extra_mask == 0;
    return a;
  endfunction

  // Random output stall, with quiet stretches when idling is disabled.
  always @(negedge clk) begin
    if (!rst) out_stall <= idle_enable && ($urandom_range(99) < 37);
  end

  // Result checker.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("result word with no query pending");
        error_count++;
      end else begin
        exp_w = pending_answers.pop_front();
        if (out_word.fit_found !== exp_w.fit_found) begin
          $error("fit_found exp %0d got %0d", exp_w.fit_found, out_word.fit_found);
          error_count++;
        end
        if (out_word.fit_entry !== exp_w.fit_entry) begin
          $error("fit_entry exp %0d got %0d", exp_w.fit_entry, out_word.fit_entry);
          error_count++;
        end
        if (out_word.fit_root !== exp_w.fit_root) begin
          $error("fit_root exp %0d got %0d", exp_w.fit_root, out_word.fit_root);
          error_count++;
        end
        if (out_word.fit_missing_mask !== exp_w.fit_missing_mask) begin
          $error("fit_missing_mask exp %h got %h", exp_w.fit_missing_mask,
                 out_word.fit_missing_mask);
          error_count++;
        end
        if (out_word.fit_extra_mask !== exp_w.fit_extra_mask) begin
          $error("fit_extra_mask exp %h got %h", exp_w.fit_extra_mask,
                 out_word.fit_extra_mask);
          error_count++;
        end
        if (out_word.fit_exact !== exp_w.fit_exact) begin
          $error("fit_exact exp %0d got %0d", exp_w.fit_exact, out_word.fit_exact);
          error_count++;
        end
        if (out_word.exact_found !== exp_w.exact_found) begin
          $error("exact_found exp %0d got %0d", exp_w.exact_found, out_word.exact_found);
          error_count++;
        end
        if (out_word.exact_entry !== exp_w.exact_entry) begin
          $error("exact_entry exp %0d got %0d", exp_w.exact_entry, out_word.exact_entry);
          error_count++;
        end
        if (out_word.scale_found !== exp_w.scale_found) begin
          $error("scale_found exp %0d got %0d", exp_w.scale_found, out_word.scale_found);
          error_count++;
        end
        if (out_word.scale_entry !== exp_w.scale_entry) begin
          $error("scale_entry exp %0d got %0d", exp_w.scale_entry, out_word.scale_entry);
          error_count++;
        end
      end
    end
  end

  // Send one word; the prediction is made when it is accepted. Valid stays
  // high after acceptance so that words can follow back to back; idle gaps and
  // the drain and write tasks drop it.
  task automatic send_word(input in_word_t w);
    while (idle_enable && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (w.command == CMD_LOAD) begin
      shadow_table[w.entry_index] = '{w.entry_mask, w.entry_tones, w.entry_is_scale};
      shadow_written[w.entry_index] = 1'b1;
      loads_sent++;
    end else begin
      pending_answers = {pending_answers, match_answer(w.sounding_mask, w.query_root)};
      queries_sent++;
    end
    @(negedge clk);
  endtask

  task automatic load_entry(input int slot, input class_mask_t m, input int tones,
                            input bit scale);
    in_word_t w;
    w = in_word_t'($urandom());
    w.command = CMD_LOAD;
    w.entry_index = 6'(slot);
    w.entry_mask = m;
    w.entry_tones = 5'(tones);
    w.entry_is_scale = scale;
    send_word(w);
  endtask

  task automatic run_query(input class_mask_t snd, input int qr);
    in_word_t w;
    w = in_word_t'({$urandom(), $urandom()});
    w.command = CMD_QUERY;
    w.sounding_mask = snd;
    w.query_root = 4'(qr);
    send_word(w);
  endtask

  // Wait until all answers are back, then let the block settle before a write.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_count(input int n);
    in_valid <= 1'b0;
    cfg_data <= 7'(n);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    search_count = 7'(n);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < SLOTS && shadow_written[n]) n++;
    return n;
  endfunction

  // Load a small library of common chords and scales, then query it.
  task automatic test_directed();
    load_entry(0, 12'h091, 3, 0);   // major triad
    load_entry(1, 12'h089, 3, 0);   // minor triad
    load_entry(2, 12'h491, 4, 0);   // dominant seventh
    load_entry(3, 12'h001, 1, 0);   // single tone, never a chord
    load_entry(4, 12'hAB5, 7, 1);   // major scale
    load_entry(5, 12'hFFF, 12, 1);  // chromatic scale
    load_entry(6, 12'h295, 5, 1);   // pentatonic
    load_entry(7, 12'hFFF, 16, 0);  // full mask with oversized tone count
    write_count(0);
    run_query(12'h091, 0);          // nothing searched
    drain_answers();
    write_count(8);
    run_query(12'h000, 0);          // empty sounding set
    run_query(12'h091, 0);          // exact C major
    run_query(12'h091 << 2, 2);
    run_query(12'h001, 0);          // single class: no exact match
    run_query(12'h491, 7);          // bass elsewhere
    run_query(12'h089, 15);         // root folded modulo 12
    run_query(12'hFFF, 11);
    run_query(12'h802, 12);
    drain_answers();
  endtask

  task automatic fill_table();
    for (int s = 0; s < SLOTS; s++)
      load_entry(s, class_mask_t'($urandom()), $urandom_range(16), $urandom_range(3) == 0);
  endtask

  // A count above the slot count searches every slot; the table is full here.
  task automatic test_capped_count();
    drain_answers();
    write_count(127);
    run_query(12'h091, 0);
    drain_answers();
  endtask

  // Random mix of loads and queries under several table sizes.
  task automatic test_random(input int items);
    int n, lim, s;
    class_mask_t m;
    for (int i = 0; i < items; i++) begin
      if (i % 300 == 0) begin
        drain_answers();
        case ((i / 300) % 4)
          0: n = 1;
          1: n = 64;
          2: n = 64 + $urandom_range(63);
          default: n = $urandom_range(64);
        endcase
        write_count(n);
      end
      idle_enable = !(i >= 600 && i < 750);
      if (i == 900) drain_answers();
      lim = (search_count > SLOTS) ? SLOTS : search_count;
      if ($urandom_range(3) == 0) begin
        s = $urandom_range(63);
        load_entry(s, class_mask_t'($urandom()), $urandom_range(31), $urandom_range(1));
      end else begin
        case ($urandom_range(3))
          0: m = class_mask_t'($urandom());
          1: m = transpose(shadow_table[$urandom_range(lim > 0 ? lim - 1 : 0)].mask,
                           $urandom_range(11));
          2: m = class_mask_t'(1 << $urandom_range(11));
          default: m = class_mask_t'($urandom()) & class_mask_t'($urandom());
        endcase
        run_query(m, $urandom_range(15));
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    fill_table();
    test_capped_count();
    test_random(1450 - 16 - SLOTS);
    drain_answers();
    $display("Ran %0d loads and %0d queries; %0d result words checked.",
             loads_sent, queries_sent, answers_seen);
    $display("Covered empty, single, full and folded-root queries at table sizes 0..127.");
    if (error_count == 0 && pending_answers.size() == 0)
      $display("chord_template_best_fit verification clean");
    else
      $display("chord_template_best_fit verification failed");
    $finish;
  end

endmodule
